FILE: design/uart8n1_pkg.sv
// Shared constants, types and helpers for the 8N1 serial transceiver core.
// No dependencies.
`default_nettype none

package uart8n1_pkg;

  localparam int unsigned TimerW   = 16;
  localparam int unsigned BitIdxW  = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [BitIdxW-1:0] DataBits  = 4'd8;
  localparam logic [BitIdxW-1:0] LastIdx   = 4'd10;
  localparam logic [TimerW-1:0]  MinPeriod = 16'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTicksPerBit = 1'b0,
    CfgMsbFirst    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             tx_line;
    logic             tx_ready;
    logic             rx_valid;
    logic [ByteW-1:0] rx_data;
  } result_t;

  // Position in the byte of data bit number idx (1..8).
  function automatic logic [2:0] bit_pos(input logic [BitIdxW-1:0] idx,
                                         input logic msb_first);
    logic [BitIdxW-1:0] pos;
    pos = msb_first ? (DataBits - idx) : (idx - 4'd1);
    return pos[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/uart_8n1_transceiver_core.sv
// Top level of the 8N1 full-duplex serial transceiver core.
// Depends on uart8n1_pkg.
//
// Usage: each transfer on the input channel (in_valid_i / in_stall_o) is one
// line tick: the sampled rx line, an optional send request with its byte and
// an optional acknowledge of the received byte. Each input transfer yields
// exactly one result transfer on the output channel (out_valid_o /
// out_stall_i) carrying tx line level, tx ready, rx valid and rx data as they
// stand after that tick.
// The tick is computed from the state registers in the cycle of the transfer
// and the result is registered. Throughput is one tick per cycle while
// in_stall_o is low; an output register plus a one-entry skid register let
// a new tick be taken while a result still waits. in_stall_o rises only
// when both hold results, i.e. after an input transfer at an edge where the
// waiting result was stalled.
// Reset puts the line idle (tx high, rx previous level high), clears both
// frame engines, empties the result registers, and loads ticks_per_bit = 16
// and msb_first = 1. Configuration writes take effect on the next tick.
`default_nettype none

module uart_8n1_transceiver_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [uart8n1_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [uart8n1_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              rx_line_i,
  input  wire logic                              send_valid_i,
  input  wire logic [uart8n1_pkg::ByteW-1:0]     send_data_i,
  input  wire logic                              read_ack_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   tx_line_o,
  output logic                                   tx_ready_o,
  output logic                                   rx_valid_o,
  output logic [uart8n1_pkg::ByteW-1:0]          rx_data_o
);
  import uart8n1_pkg::*;

  // configuration
  logic [TimerW-1:0] tpb_q;
  logic              msb_first_q;

  // transmitter
  logic [TimerW-1:0]  tx_timer_q, tx_timer_d;
  logic [BitIdxW-1:0] tx_idx_q, tx_idx_d;
  logic               tx_active_q, tx_active_d;
  logic [ByteW-1:0]   tx_shift_q, tx_shift_d;
  logic               tx_level_q, tx_level_d;

  // receiver
  logic [TimerW-1:0]  rx_timer_q, rx_timer_d;
  logic [BitIdxW-1:0] rx_idx_q, rx_idx_d;
  logic               rx_active_q, rx_active_d;
  logic [ByteW-1:0]   rx_accum_q, rx_accum_d;
  logic [ByteW-1:0]   rx_hold_q, rx_hold_d;
  logic               rx_flag_q, rx_flag_d;
  logic               rx_prev_q;

  // result path
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;

  logic              in_xfer, out_xfer;
  logic [TimerW-1:0] period;
  logic [TimerW:0]   tx_next;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i & ~skid_valid_q;
  assign out_xfer   = out_valid_q & ~out_stall_i;

  assign period  = (tpb_q < MinPeriod) ? MinPeriod : tpb_q;
  assign tx_next = {1'b0, tx_timer_q} + 17'd1;

  always_comb begin
    tx_timer_d  = tx_timer_q;
    tx_idx_d    = tx_idx_q;
    tx_active_d = tx_active_q;
    tx_shift_d  = tx_shift_q;
    tx_level_d  = tx_level_q;

    if (tx_next >= {1'b0, period}) begin
      tx_timer_d = '0;
      if (tx_active_q) begin
        if (tx_idx_q == '0) begin
          tx_level_d = 1'b0;
        end else if (tx_idx_q <= DataBits) begin
          tx_level_d = tx_shift_q[bit_pos(tx_idx_q, msb_first_q)];
        end else begin
          tx_level_d  = 1'b1;
          tx_active_d = 1'b0;
        end
        tx_idx_d = tx_idx_q + 4'd1;
      end else begin
        tx_idx_d   = '0;
        tx_level_d = 1'b1;
      end
    end else begin
      tx_timer_d = tx_next[TimerW-1:0];
    end

    if (send_valid_i && !tx_active_d) begin
      tx_shift_d  = send_data_i;
      tx_idx_d    = '0;
      tx_active_d = 1'b1;
    end
  end

  always_comb begin
    rx_timer_d  = rx_timer_q;
    rx_idx_d    = rx_idx_q;
    rx_active_d = rx_active_q;
    rx_accum_d  = rx_accum_q;
    rx_hold_d   = rx_hold_q;
    rx_flag_d   = rx_flag_q & ~read_ack_i;

    if (rx_active_q) begin
      if (rx_timer_q <= 16'd1) begin
        rx_timer_d = period;
        if (rx_idx_q == '0) begin
          if (rx_line_i) begin
            rx_active_d = 1'b0;
          end
        end else if (rx_idx_q <= DataBits) begin
          if (rx_line_i) begin
            rx_accum_d[bit_pos(rx_idx_q, msb_first_q)] = 1'b1;
          end
        end else begin
          rx_active_d = 1'b0;
          if (rx_line_i) begin
            rx_hold_d = rx_accum_q;
            rx_flag_d = 1'b1;
          end
        end
        rx_idx_d = rx_idx_q + 4'd1;
      end else begin
        rx_timer_d = rx_timer_q - 16'd1;
      end
    end else if (rx_prev_q && !rx_line_i) begin
      rx_active_d = 1'b1;
      rx_idx_d    = '0;
      rx_accum_d  = '0;
      rx_timer_d  = period >> 1;
    end
  end

  always_comb begin
    res.tx_line  = tx_level_d;
    res.tx_ready = ~tx_active_d;
    res.rx_valid = rx_flag_d;
    res.rx_data  = rx_hold_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q       <= 16'd16;
      msb_first_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTicksPerBit: tpb_q       <= cfg_data_i;
        CfgMsbFirst:    msb_first_q <= cfg_data_i[0];
        default:        tpb_q       <= tpb_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_timer_q  <= '0;
      tx_idx_q    <= '0;
      tx_active_q <= 1'b0;
      tx_shift_q  <= '0;
      tx_level_q  <= 1'b1;
      rx_timer_q  <= '0;
      rx_idx_q    <= '0;
      rx_active_q <= 1'b0;
      rx_accum_q  <= '0;
      rx_hold_q   <= '0;
      rx_flag_q   <= 1'b0;
      rx_prev_q   <= 1'b1;
    end else if (in_xfer) begin
      tx_timer_q  <= tx_timer_d;
      tx_idx_q    <= tx_idx_d;
      tx_active_q <= tx_active_d;
      tx_shift_q  <= tx_shift_d;
      tx_level_q  <= tx_level_d;
      rx_timer_q  <= rx_timer_d;
      rx_idx_q    <= rx_idx_d;
      rx_active_q <= rx_active_d;
      rx_accum_q  <= rx_accum_d;
      rx_hold_q   <= rx_hold_d;
      rx_flag_q   <= rx_flag_d;
      rx_prev_q   <= rx_line_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid_q && !out_xfer) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (in_xfer) begin
      if (out_valid_q && !out_xfer) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_line_o   = out_q.tx_line;
  assign tx_ready_o  = out_q.tx_ready;
  assign rx_valid_o  = out_q.rx_valid;
  assign rx_data_o   = out_q.rx_data;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while output register is empty");

  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("input transfer did not produce a pending result");

  a_tx_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tx_active_q |-> tx_level_q)
    else $error("tx line low while no frame is in progress");

  a_tx_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_idx_q <= LastIdx)
    else $error("tx bit index out of range");

  a_rx_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_idx_q <= LastIdx)
    else $error("rx bit index out of range");

endmodule

`default_nettype wire
